>>> rtl/modbus_rtu_response_checker_macros.svh
// Assertion macros shared by the checker of the Modbus RTU response checker.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MRRC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mrrc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MRRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mrrc assertion failed");

`endif

>>> rtl/mrrc_pkg.sv
// Types, constants and the CRC-16/MODBUS byte update for the response checker.
`timescale 1ns / 1ps
package mrrc_pkg;

	localparam int DEF_PREFIX_BYTES     = 300;
	localparam int DEF_PAYLOAD_CAPACITY = 256;
	localparam int QUEUE_DEPTH          = 2;

	localparam logic [7:0]  EXC_BIT   = 8'h80;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	// Register indexes (byte address 4*i)
	localparam logic [1:0] REG_SLAVE_ADDR  = 2'd0;
	localparam logic [1:0] REG_FUNC_CODE   = 2'd1;
	localparam logic [1:0] REG_RX_LIMIT    = 2'd2;
	localparam logic [1:0] REG_PREFIX_MODE = 2'd3;

	// Verdict status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_RESP   = 3'd1;
	localparam logic [2:0] ST_BAD_ADDR  = 3'd2;
	localparam logic [2:0] ST_BAD_CRC   = 3'd3;
	localparam logic [2:0] ST_EXCEPTION = 3'd4;
	localparam logic [2:0] ST_OVERFLOW  = 3'd5;

	typedef struct packed {
		logic [7:0] slave_address;
		logic [7:0] function_code;
		logic [9:0] rx_limit;
		logic       prefix_mode;
	} mrrc_cfg_t;

	// Frame facts settled in the front, on the last beat of a frame
	typedef struct packed {
		logic       n_zero;
		logic       addr_ok;
		logic       is_exc;
		logic [7:0] exc;
		logic [9:0] len;
		logic [9:0] pstart;
		logic       split;
	} mrrc_verdict_t;

	// One classified beat as it travels through the queue
	typedef struct packed {
		logic [7:0]    data;
		logic [9:0]    index;
		logic          take;
		logic          last;
		logic          feed_prefix;
		mrrc_verdict_t vd;
	} mrrc_item_t;

	// Reflected CRC-16 update over one byte, LSB first
	function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/mrrc_front.sv
// Front end: accepts beats, tracks frame position and header/tail fields, classifies.
`timescale 1ns / 1ps
module mrrc_front
	import mrrc_pkg::*;
#(
	parameter int PREFIX_BYTES = DEF_PREFIX_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mrrc_cfg_t  cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       push,
	output mrrc_item_t item
);

	localparam logic [9:0] P0 = 10'(PREFIX_BYTES);
	localparam logic [9:0] P1 = 10'(PREFIX_BYTES + 1);
	localparam logic [9:0] P2 = 10'(PREFIX_BYTES + 2);

	logic [9:0] count_q;
	logic       addr_ok_q, is_exc_q, t_is_exc_q;
	logic [7:0] exc_q, t_exc_q;
	logic [1:0] tail_q;

	logic [9:0] count_d;
	logic       addr_ok_d, is_exc_d, t_is_exc_d;
	logic [7:0] exc_d, t_exc_d;
	logic [1:0] tail_d;
	logic       take, last_eff, split;
	logic [7:0] exc_form;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign exc_form = cfg.function_code | EXC_BIT;
	assign take     = !kind && (count_q < cfg.rx_limit);
	assign last_eff = kind || last_byte;

	// Header and tail capture for the current beat
	always_comb begin
		count_d    = take ? count_q + 10'd1 : count_q;
		addr_ok_d  = addr_ok_q;
		is_exc_d   = is_exc_q;
		exc_d      = exc_q;
		tail_d     = tail_q;
		t_is_exc_d = t_is_exc_q;
		t_exc_d    = t_exc_q;
		if (take) begin
			if (count_q == 10'd0) addr_ok_d = (rx_byte == cfg.slave_address);
			if (count_q == 10'd1) is_exc_d = (rx_byte == exc_form);
			if (count_q == 10'd2) exc_d = rx_byte;
			if (count_q == P0 && rx_byte == cfg.slave_address) tail_d[0] = 1'b1;
			if (count_q == P1) begin
				if (rx_byte == cfg.function_code) tail_d[1] = 1'b1;
				t_is_exc_d = (rx_byte == exc_form);
			end
			if (count_q == P2) t_exc_d = rx_byte;
		end
		split = cfg.prefix_mode && (count_d >= P2) && (tail_d == 2'b11);
	end

	// Classified beat
	always_comb begin
		item.data        = kind ? 8'h00 : rx_byte;
		item.index       = count_q;
		item.take        = take;
		item.last        = last_eff;
		item.feed_prefix = (count_q >= P0);
		item.vd.n_zero   = (count_d == 10'd0);
		item.vd.addr_ok  = split ? 1'b1 : addr_ok_d;
		item.vd.is_exc   = split ? t_is_exc_d : is_exc_d;
		item.vd.exc      = split ? t_exc_d : exc_d;
		item.vd.len      = split ? count_d - P0 : count_d;
		item.vd.pstart   = split ? P2 : 10'd2;
		item.vd.split    = split;
	end

	// Frame state; a frame end returns it to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			addr_ok_q  <= 1'b0;
			is_exc_q   <= 1'b0;
			exc_q      <= '0;
			tail_q     <= '0;
			t_is_exc_q <= 1'b0;
			t_exc_q    <= '0;
		end else if (push) begin
			if (last_eff) begin
				count_q    <= '0;
				addr_ok_q  <= 1'b0;
				is_exc_q   <= 1'b0;
				exc_q      <= '0;
				tail_q     <= '0;
				t_is_exc_q <= 1'b0;
				t_exc_q    <= '0;
			end else begin
				count_q    <= count_d;
				addr_ok_q  <= addr_ok_d;
				is_exc_q   <= is_exc_d;
				exc_q      <= exc_d;
				tail_q     <= tail_d;
				t_is_exc_q <= t_is_exc_d;
				t_exc_q    <= t_exc_d;
			end
		end
	end

endmodule

>>> rtl/mrrc_queue.sv
// Short register FIFO between front and back.
`timescale 1ns / 1ps
module mrrc_queue
	import mrrc_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/mrrc_back.sv
// Back end: running CRCs, frame verdict and the registered result beat.
`timescale 1ns / 1ps
module mrrc_back
	import mrrc_pkg::*;
#(
	parameter int PAYLOAD_CAPACITY = DEF_PAYLOAD_CAPACITY
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	output logic       q_pop,
	input  mrrc_item_t item,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] echo_byte,
	output logic [9:0] byte_index,
	output logic       accepted,
	output logic       frame_done,
	output logic [2:0] status,
	output logic [7:0] exception_code,
	output logic [9:0] payload_start,
	output logic [9:0] payload_length,
	output logic       has_data_packet
);

	localparam logic [9:0] CAP = 10'(PAYLOAD_CAPACITY);

	logic [15:0] crc_s_q, crc_p_q;
	logic [15:0] crc_s_n, crc_p_n, crc_sel;
	logic        crc_ok;
	logic [2:0]  st_d;
	logic [7:0]  code_d;
	logic [9:0]  start_d, plen_d;
	logic        out_valid_q;

	assign out_valid = out_valid_q;
	assign q_pop     = q_valid && (!out_valid_q || out_ready);

	// CRC update for this beat
	always_comb begin
		crc_s_n = item.take ? crc16_feed(crc_s_q, item.data) : crc_s_q;
		crc_p_n = (item.take && item.feed_prefix) ? crc16_feed(crc_p_q, item.data) : crc_p_q;
		crc_sel = item.vd.split ? crc_p_n : crc_s_n;
		crc_ok  = (crc_sel == 16'h0000);
	end

	// Verdict, in priority order
	always_comb begin
		st_d    = ST_OK;
		code_d  = '0;
		start_d = '0;
		plen_d  = '0;
		if (item.vd.n_zero) begin
			st_d = ST_NO_RESP;
		end else if (!item.vd.addr_ok) begin
			st_d = ST_BAD_ADDR;
		end else if (item.vd.is_exc && item.vd.len == 10'd5) begin
			if (crc_ok) begin
				st_d   = ST_EXCEPTION;
				code_d = item.vd.exc;
			end else begin
				st_d = ST_BAD_CRC;
			end
		end else if (item.vd.len < 10'd4) begin
			st_d = ST_BAD_CRC;
		end else if (!crc_ok) begin
			st_d = ST_BAD_CRC;
		end else if ((item.vd.len - 10'd4) > CAP) begin
			st_d = ST_OVERFLOW;
		end else begin
			st_d    = ST_OK;
			start_d = item.vd.pstart;
			plen_d  = item.vd.len - 10'd4;
		end
	end

	// CRC state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_s_q     <= CRC_INIT;
			crc_p_q     <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				crc_s_q     <= item.last ? CRC_INIT : crc_s_n;
				crc_p_q     <= item.last ? CRC_INIT : crc_p_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result beat payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			echo_byte       <= item.data;
			byte_index      <= item.index;
			accepted        <= item.take;
			frame_done      <= item.last;
			status          <= item.last ? st_d : ST_OK;
			exception_code  <= item.last ? code_d : 8'h00;
			payload_start   <= item.last ? start_d : 10'd0;
			payload_length  <= item.last ? plen_d : 10'd0;
			has_data_packet <= item.last && item.vd.split;
		end
	end

endmodule

>>> rtl/modbus_rtu_response_checker.sv
// Modbus RTU response checker top level: register port, front, queue and back.
`timescale 1ns / 1ps
// Takes one received byte (or a timeout beat) per cycle while in_ready is high and
// returns one result beat per input beat, in order, echoing the byte with its frame
// index; the last beat of a frame also carries the verdict. Sustained rate is one beat
// per clock while out_ready stays high: the front classifies a beat in the cycle it is
// accepted, a two-entry queue separates it from the back, and the back does the
// byte-wide CRC-16 update and verdict into its output register. Configuration
// registers sit at byte addresses 0, 4, 8 and 12 and should be written between frames.
module modbus_rtu_response_checker
	import mrrc_pkg::*;
#(
	parameter int PREFIX_BYTES     = DEF_PREFIX_BYTES,
	parameter int PAYLOAD_CAPACITY = DEF_PAYLOAD_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  rx_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  echo_byte,
	output logic [9:0]  byte_index,
	output logic        accepted,
	output logic        frame_done,
	output logic [2:0]  status,
	output logic [7:0]  exception_code,
	output logic [9:0]  payload_start,
	output logic [9:0]  payload_length,
	output logic        has_data_packet,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int ITEM_W = $bits(mrrc_item_t);

	mrrc_cfg_t  cfg_q;
	mrrc_item_t f_item, b_item;
	logic       push, q_full, q_valid, q_pop;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address <= 8'd1;
			cfg_q.function_code <= 8'd3;
			cfg_q.rx_limit      <= 10'd512;
			cfg_q.prefix_mode   <= 1'b0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_SLAVE_ADDR:  cfg_q.slave_address <= pwdata[7:0];
				REG_FUNC_CODE:   cfg_q.function_code <= pwdata[7:0];
				REG_RX_LIMIT:    cfg_q.rx_limit      <= pwdata[9:0];
				REG_PREFIX_MODE: cfg_q.prefix_mode   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[3:2])
			REG_SLAVE_ADDR:  prdata = {24'h0, cfg_q.slave_address};
			REG_FUNC_CODE:   prdata = {24'h0, cfg_q.function_code};
			REG_RX_LIMIT:    prdata = {22'h0, cfg_q.rx_limit};
			REG_PREFIX_MODE: prdata = {31'h0, cfg_q.prefix_mode};
			default:         prdata = 32'h0;
		endcase
	end

	mrrc_front #(
		.PREFIX_BYTES (PREFIX_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.rx_byte   (rx_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.push      (push),
		.item      (f_item)
	);

	mrrc_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (f_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rdata     (b_item)
	);

	mrrc_back #(
		.PAYLOAD_CAPACITY (PAYLOAD_CAPACITY)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.item            (b_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.echo_byte       (echo_byte),
		.byte_index      (byte_index),
		.accepted        (accepted),
		.frame_done      (frame_done),
		.status          (status),
		.exception_code  (exception_code),
		.payload_start   (payload_start),
		.payload_length  (payload_length),
		.has_data_packet (has_data_packet)
	);

endmodule

>>> rtl/mrrc_checker.sv
// Port-level assertions for the response checker, bound to the top level.
`timescale 1ns / 1ps
`include "modbus_rtu_response_checker_macros.svh"
module mrrc_checker
	import mrrc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] echo_byte,
	input logic [9:0] byte_index,
	input logic       frame_done,
	input logic [2:0] status,
	input logic [7:0] exception_code,
	input logic [9:0] payload_start,
	input logic [9:0] payload_length,
	input logic       has_data_packet
);

	// A stalled result beat holds
	`MRRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(echo_byte) && $stable(byte_index) && $stable(status))

	// Mid-frame beats carry no verdict
	`MRRC_ASSERT_NOW(a_mid_clean, out_valid && !frame_done, status == ST_OK && exception_code == 8'h00 && payload_length == 10'd0 && !has_data_packet)

	// Payload window only on a good frame
	`MRRC_ASSERT_NOW(a_window_ok, out_valid && status != ST_OK, payload_start == 10'd0 && payload_length == 10'd0)

	// An exception code only with exception status
	`MRRC_ASSERT_NOW(a_exc_status, out_valid && exception_code != 8'h00, frame_done && status == ST_EXCEPTION)

endmodule

bind modbus_rtu_response_checker mrrc_checker u_mrrc_checker (.*);

>>> dv/modbus_rtu_response_checker_test.sv
// Self-checking testbench for the Modbus RTU response checker: beat driver, monitor, predictor.
`timescale 1ns / 1ps
module modbus_rtu_response_checker_test;
	import mrrc_pkg::*;

	localparam int PFX         = DEF_PREFIX_BYTES;
	localparam int PAYLOAD_CAP = DEF_PAYLOAD_CAPACITY;
	localparam int ITEM_GOAL   = 1350;
	localparam int CYCLE_LIMIT = 400000;

	// Input beat kinds
	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_TIMEOUT = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
		logic       last_byte;
	} rx_beat_t;

	typedef struct packed {
		logic [7:0] echo_byte;
		logic [9:0] byte_index;
		logic       accepted;
		logic       frame_done;
		logic [2:0] status;
		logic [7:0] exception_code;
		logic [9:0] payload_start;
		logic [9:0] payload_length;
		logic       has_data_packet;
	} echo_beat_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  echo_byte;
	logic [9:0]  byte_index;
	logic        accepted;
	logic        frame_done;
	logic [2:0]  status;
	logic [7:0]  exception_code;
	logic [9:0]  payload_start;
	logic [9:0]  payload_length;
	logic        has_data_packet;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'h0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	modbus_rtu_response_checker dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.rx_byte        (rx_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.echo_byte      (echo_byte),
		.byte_index     (byte_index),
		.accepted       (accepted),
		.frame_done     (frame_done),
		.status         (status),
		.exception_code (exception_code),
		.payload_start  (payload_start),
		.payload_length (payload_length),
		.has_data_packet(has_data_packet),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Register mirror and frame state of the predictor
	mrrc_cfg_t cfg = '{slave_address: 8'd1, function_code: 8'd3, rx_limit: 10'd512,
		prefix_mode: 1'b0};
	logic [9:0]  fr_count = '0;
	logic [15:0] crc_all = CRC_INIT;
	logic [15:0] crc_tail = CRC_INIT;
	logic        head_addr_ok = 1'b0;
	logic        head_exc = 1'b0;
	logic [7:0]  head_code = '0;
	logic [1:0]  tail_hits = '0;
	logic        tail_exc = 1'b0;
	logic [7:0]  tail_code = '0;

	rx_beat_t    rx_pending[$];
	echo_beat_t  echo_due[$];
	logic [7:0]  frame_buf[$];
	rx_beat_t    cur_beat;
	int          queued = 0;
	int          mismatch_count = 0;
	int          results_seen = 0;
	int          cycle_count = 0;
	int          in_wait = 0;
	int          in_calm = 0;
	int          out_wait = 0;
	int          out_calm = 0;

	// CRC-16/MODBUS, reflected, one byte LSB first
	function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ 16'hA001;
			end
		end
		return c;
	endfunction

	// Expected result for one accepted beat; advances the frame state
	function automatic echo_beat_t predict_beat(rx_beat_t t);
		echo_beat_t r;
		logic       fin;
		logic [7:0] exc_form;
		logic       split;
		logic       addr_ok;
		logic       is_exc;
		logic [7:0] code;
		logic [15:0] crc;
		int         i;
		int         n;
		int         base;
		int         span;
		r = '0;
		r.byte_index = fr_count;
		fin = t.last_byte;
		if (t.kind == KIND_TIMEOUT) begin
			fin = 1'b1;
		end else begin
			r.echo_byte = t.rx_byte;
			if (fr_count < cfg.rx_limit) begin
				r.accepted = 1'b1;
				i = fr_count;
				exc_form = cfg.function_code | EXC_BIT;
				if (i == 0) head_addr_ok = (t.rx_byte == cfg.slave_address);
				if (i == 1) head_exc = (t.rx_byte == exc_form);
				if (i == 2) head_code = t.rx_byte;
				if (i == PFX && t.rx_byte == cfg.slave_address) tail_hits[0] = 1'b1;
				if (i == PFX + 1) begin
					if (t.rx_byte == cfg.function_code) tail_hits[1] = 1'b1;
					tail_exc = (t.rx_byte == exc_form);
				end
				if (i == PFX + 2) tail_code = t.rx_byte;
				crc_all = crc16_step(crc_all, t.rx_byte);
				if (i >= PFX) crc_tail = crc16_step(crc_tail, t.rx_byte);
				fr_count = fr_count + 10'd1;
			end
		end
		if (fin) begin
			n = fr_count;
			split = cfg.prefix_mode && n >= PFX + 2 && tail_hits == 2'b11;
			base = split ? PFX : 0;
			span = n - base;
			addr_ok = split ? 1'b1 : head_addr_ok;
			is_exc = split ? tail_exc : head_exc;
			code = split ? tail_code : head_code;
			crc = split ? crc_tail : crc_all;
			r.frame_done = 1'b1;
			r.has_data_packet = split;
			if (n == 0) begin
				r.status = ST_NO_RESP;
			end else if (!addr_ok) begin
				r.status = ST_BAD_ADDR;
			end else if (is_exc && span == 5) begin
				if (crc == 16'h0000) begin
					r.status = ST_EXCEPTION;
					r.exception_code = code;
				end else begin
					r.status = ST_BAD_CRC;
				end
			end else if (span < 4 || crc != 16'h0000) begin
				r.status = ST_BAD_CRC;
			end else if (span - 4 > PAYLOAD_CAP) begin
				r.status = ST_OVERFLOW;
			end else begin
				r.status = ST_OK;
				r.payload_start = 10'(base + 2);
				r.payload_length = 10'(span - 4);
			end
			// frame state back to its reset value
			fr_count = '0;
			crc_all = CRC_INIT;
			crc_tail = CRC_INIT;
			head_addr_ok = 1'b0;
			head_exc = 1'b0;
			head_code = '0;
			tail_hits = '0;
			tail_exc = 1'b0;
			tail_code = '0;
		end
		return r;
	endfunction

	// Wait drawn per beat; occasional calm stretches with no waiting
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) calm = $urandom_range(8, 40);
		return $urandom_range(0, 15);
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	task automatic cmp_field(string name, int got, int want);
		if (got != want) begin
			report_mismatch($sformatf("result %0d %s got %0d expected %0d",
				results_seen, name, got, want));
		end
	endtask

	// Input side: feed beats from the pending queue, predict on each accepted beat
	always @(posedge clk) begin : drive
		rx_beat_t nxt;
		logic     vld;
		if (arst_n) begin
			vld = in_valid;
			if (in_valid && in_ready) begin
				echo_due.push_back(predict_beat(cur_beat));
				vld = 1'b0;
				in_wait = draw_wait(in_calm);
			end
			if (!vld) begin
				if (in_wait > 0) begin
					in_wait--;
				end else if (rx_pending.size() > 0) begin
					nxt = rx_pending.pop_front();
					cur_beat = nxt;
					vld = 1'b1;
					kind <= nxt.kind;
					rx_byte <= nxt.rx_byte;
					last_byte <= nxt.last_byte;
				end
			end
			in_valid <= vld;
		end
	end

	// Output side: random back-pressure, compare each result beat in order
	always @(posedge clk) begin : observe
		echo_beat_t want;
		logic       rdy;
		if (arst_n) begin
			rdy = out_ready;
			if (out_valid && out_ready) begin
				if (echo_due.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with none expected",
						results_seen));
				end else begin
					want = echo_due.pop_front();
					cmp_field("echo_byte", echo_byte, want.echo_byte);
					cmp_field("byte_index", byte_index, want.byte_index);
					cmp_field("accepted", accepted, want.accepted);
					cmp_field("frame_done", frame_done, want.frame_done);
					cmp_field("status", status, want.status);
					cmp_field("exception_code", exception_code, want.exception_code);
					cmp_field("payload_start", payload_start, want.payload_start);
					cmp_field("payload_length", payload_length, want.payload_length);
					cmp_field("has_data_packet", has_data_packet, want.has_data_packet);
				end
				results_seen++;
				rdy = 1'b0;
				out_wait = draw_wait(out_calm);
			end
			if (!rdy) begin
				if (out_wait > 0) begin
					out_wait--;
				end else begin
					rdy = 1'b1;
				end
			end
			out_ready <= rdy;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("modbus_rtu_response_checker_test NOT OK");
			$finish;
		end
	end

	// APB write: setup, then access; register taken on the access edge
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SLAVE_ADDR:  cfg.slave_address = val[7:0];
			REG_FUNC_CODE:   cfg.function_code = val[7:0];
			REG_RX_LIMIT:    cfg.rx_limit = val[9:0];
			REG_PREFIX_MODE: cfg.prefix_mode = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [7:0] addr, logic [7:0] fn, logic [9:0] lim, logic pfx);
		write_reg(REG_SLAVE_ADDR, {24'h0, addr});
		write_reg(REG_FUNC_CODE, {24'h0, fn});
		write_reg(REG_RX_LIMIT, {22'h0, lim});
		write_reg(REG_PREFIX_MODE, {31'h0, pfx});
	endtask

	task automatic wait_drained();
		while (rx_pending.size() != 0 || in_valid || echo_due.size() != 0) @(posedge clk);
	endtask

	task automatic push_beat(logic k, logic [7:0] b, logic l);
		rx_beat_t t;
		t.kind = k;
		t.rx_byte = b;
		t.last_byte = l;
		rx_pending.push_back(t);
		queued++;
	endtask

	// Append CRC (low byte first) over the buffer from a given index
	task automatic add_crc(int from);
		logic [15:0] c;
		c = CRC_INIT;
		for (int i = from; i < frame_buf.size(); i++) c = crc16_step(c, frame_buf[i]);
		frame_buf.push_back(c[7:0]);
		frame_buf.push_back(c[15:8]);
	endtask

	task automatic build_reply(logic [7:0] fn, int plen, int from);
		frame_buf.push_back(cfg.slave_address);
		frame_buf.push_back(fn);
		repeat (plen) frame_buf.push_back(8'($urandom));
		add_crc(from);
	endtask

	task automatic corrupt_bit();
		int k;
		k = $urandom_range(0, frame_buf.size() - 1);
		frame_buf[k] = frame_buf[k] ^ 8'(1 << $urandom_range(0, 7));
	endtask

	// Emit the buffer as beats; the frame ends on the last byte or on a timeout beat
	task automatic send_frame(bit via_timeout);
		int last_i;
		last_i = frame_buf.size() - 1;
		foreach (frame_buf[i]) push_beat(KIND_BYTE, frame_buf[i], !via_timeout && i == last_i);
		if (via_timeout || frame_buf.size() == 0) begin
			push_beat(KIND_TIMEOUT, 8'($urandom), 1'($urandom));
		end
		frame_buf.delete();
	endtask

	task automatic queue_random_frame();
		int pick;
		logic [7:0] fn;
		pick = $urandom_range(0, 99);
		fn = ($urandom_range(0, 7) == 0) ? 8'($urandom) : cfg.function_code;
		if (pick < 35) begin
			build_reply(fn, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
				: $urandom_range(0, 6), 0);
		end else if (pick < 50) begin
			// exception reply, sometimes one byte too long or damaged
			frame_buf.push_back(cfg.slave_address);
			frame_buf.push_back(cfg.function_code | EXC_BIT);
			frame_buf.push_back(8'($urandom));
			if ($urandom_range(0, 3) == 0) frame_buf.push_back(8'($urandom));
			add_crc(0);
			if ($urandom_range(0, 2) == 0) corrupt_bit();
		end else if (pick < 65) begin
			build_reply(fn, $urandom_range(0, 8), 0);
			corrupt_bit();
		end else if (pick < 72) begin
			build_reply(fn, $urandom_range(0, 6), 0);
			frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
		end else if (pick < 82) begin
			// short frame
			frame_buf.push_back(cfg.slave_address);
			repeat ($urandom_range(0, 2)) frame_buf.push_back(8'($urandom));
		end else if (pick < 95) begin
			repeat ($urandom_range(1, 16)) frame_buf.push_back(8'($urandom));
		end
		send_frame($urandom_range(0, 4) == 0 || pick >= 95);
	endtask

	task automatic random_frames(int count);
		int stop;
		stop = queued + count;
		while (queued < stop) queue_random_frame();
	endtask

	// Leading data packet followed by a response tail
	task automatic queue_prefix_frame();
		repeat (PFX) frame_buf.push_back(8'($urandom));
		case ($urandom_range(0, 3))
			0: build_reply(cfg.function_code, $urandom_range(0, 8), PFX);
			1: begin
				frame_buf.push_back(cfg.slave_address);
				frame_buf.push_back(cfg.function_code | EXC_BIT);
				frame_buf.push_back(8'($urandom));
				add_crc(PFX);
			end
			2: begin
				frame_buf.push_back(cfg.slave_address);
				frame_buf.push_back(cfg.function_code);
			end
			default: build_reply(cfg.function_code ^ 8'($urandom_range(1, 255)), 2, PFX);
		endcase
		send_frame(1'b0);
	endtask

	initial begin : stimulus
		int lim;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames at reset settings (address 1, function 3)
		send_frame(1'b1);
		frame_buf = '{8'h01, 8'h03, 8'h00, 8'hFF};
		add_crc(0);
		send_frame(1'b0);
		frame_buf = '{8'h01, 8'h83, 8'h02};
		add_crc(0);
		send_frame(1'b0);
		frame_buf = '{8'hFF};
		send_frame(1'b0);
		frame_buf = '{8'h01, 8'h03};
		send_frame(1'b1);
		frame_buf = '{8'h01, 8'h03, 8'hA5, 8'h5A};
		add_crc(0);
		frame_buf[4] = frame_buf[4] ^ 8'h01;
		send_frame(1'b0);
		wait_drained();

		// Low extremes, full receive range, payload one over capacity
		set_config(8'h00, 8'h00, 10'd1023, 1'b0);
		build_reply(cfg.function_code, PAYLOAD_CAP + 1, 0);
		send_frame(1'b0);
		random_frames(45);
		wait_drained();

		// High extremes, smallest receive limit
		set_config(8'hFF, 8'hFF, 10'd4, 1'b0);
		random_frames(45);
		wait_drained();

		// Data packet split
		set_config(8'($urandom), 8'($urandom), 10'd512, 1'b1);
		queue_prefix_frame();
		random_frames(45);
		wait_drained();

		// Function code with the exception bit set, so an exception tail can split
		set_config(8'h11, 8'h84, 10'd1023, 1'b1);
		queue_prefix_frame();
		random_frames(45);
		wait_drained();

		while (queued < ITEM_GOAL) begin
			case ($urandom_range(0, 3))
				0: lim = 4;
				1: lim = $urandom_range(4, 40);
				2: lim = $urandom_range(4, 1023);
				default: lim = 1023;
			endcase
			set_config(8'($urandom), 8'($urandom), 10'(lim), 1'($urandom));
			random_frames(45);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("modbus_rtu_response_checker_test OK");
		end else begin
			$display("modbus_rtu_response_checker_test NOT OK");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/mrrc_pkg.sv
rtl/mrrc_front.sv
rtl/mrrc_queue.sv
rtl/mrrc_back.sv
rtl/modbus_rtu_response_checker.sv
rtl/mrrc_checker.sv
dv/modbus_rtu_response_checker_test.sv
